FILE: rtl/acg_pkg.sv
// ----------------------------------------------------------------------------
// acg_pkg
// Types, codes and field layouts shared by the actuator command gatekeeper.
// ----------------------------------------------------------------------------
package acg_pkg;

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int IN_DW   = 192;
  localparam int IN_UW   = 4;
  localparam int OUT_DW  = 72;
  localparam int OUT_UW  = 2;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_AW-1:0] CFG_SOFT_ON    = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_SOFT_MIN   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_SOFT_MAX   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_MAX_VEL    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_MAX_ACC    = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_HOST_TMO   = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_TMO_DIS    = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_STOP_DECEL = 3'd7;

  typedef enum logic [2:0] {
    ST_DISABLED = 3'd0,
    ST_IDLE     = 3'd1,
    ST_COMM     = 3'd2,
    ST_MOVING   = 3'd3,
    ST_VELOCITY = 3'd4,
    ST_STOPPING = 3'd5,
    ST_FAULTED  = 3'd6
  } st_t;

  typedef enum logic [3:0] {
    R_TICK      = 4'd0,
    R_SET_MODE  = 4'd1,
    R_ESTOP     = 4'd2,
    R_RAMP_STOP = 4'd3,
    R_CLEAR     = 4'd4,
    R_MOVE_ABS  = 4'd5,
    R_MOVE_REL  = 4'd6,
    R_RUN_VEL   = 4'd7,
    R_HEARTBEAT = 4'd8,
    R_PING      = 4'd9
  } req_t;

  localparam logic [1:0] K_ACK  = 2'd0;
  localparam logic [1:0] K_ERR  = 2'd1;
  localparam logic [1:0] K_PONG = 2'd2;
  localparam logic [1:0] K_TICK = 2'd3;

  localparam logic [2:0] E_OK      = 3'd0;
  localparam logic [2:0] E_PAYLOAD = 3'd1;
  localparam logic [2:0] E_FAULTED = 3'd2;
  localparam logic [2:0] E_BUSY    = 3'd3;
  localparam logic [2:0] E_STATE   = 3'd4;
  localparam logic [2:0] E_RANGE   = 3'd5;
  localparam logic [2:0] E_UNSUP   = 3'd6;

  localparam logic [2:0] A_NONE     = 3'd0;
  localparam logic [2:0] A_DISABLE  = 3'd1;
  localparam logic [2:0] A_ENABLE   = 3'd2;
  localparam logic [2:0] A_ESTOP    = 3'd3;
  localparam logic [2:0] A_RAMP     = 3'd4;
  localparam logic [2:0] A_MOVE_ABS = 3'd5;
  localparam logic [2:0] A_MOVE_REL = 3'd6;
  localparam logic [2:0] A_RUN_VEL  = 3'd7;

  localparam logic [3:0] F_TIMEOUT = 4'b0001;
  localparam logic [3:0] F_SOFT    = 4'b0010;
  localparam logic [3:0] F_DRIVER  = 4'b0100;
  localparam logic [3:0] F_UNSUP   = 4'b1000;

  localparam logic [7:0] MODE_DISABLED = 8'd0;
  localparam logic [7:0] MODE_POSITION = 8'd1;
  localparam logic [7:0] MODE_VELOCITY = 8'd2;
  localparam logic [7:0] MODE_COMM     = 8'd3;

  typedef struct packed {
    logic               soft_on;
    logic signed [31:0] soft_min;
    logic signed [31:0] soft_max;
    logic [31:0]        max_vel;
    logic [31:0]        max_acc;
    logic [31:0]        host_tmo;
    logic               tmo_dis;
    logic [31:0]        stop_decel;
  } cfg_t;

  typedef struct packed {
    st_t         st;
    logic [7:0]  mode;
    logic        drv;
    logic [3:0]  flt;
    logic [31:0] lht;
  } ast_t;

  typedef struct packed {
    logic [3:0]         rtype;
    logic [15:0]        seq;
    logic               len_ok;
    logic [31:0]        now;
    logic [7:0]         mode;
    logic signed [31:0] pos;
    logic signed [32:0] speed;
    logic [31:0]        accel;
    logic signed [31:0] cur;
    logic               drv_ok;
    logic               active;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [15:0] seq;
    logic [2:0]  st;
    logic [7:0]  mode;
    logic        drv;
    logic [3:0]  flt;
    logic [2:0]  action;
    logic [31:0] value;
    logic        last;
  } res_t;

endpackage

FILE: rtl/acg_core.sv
// ----------------------------------------------------------------------------
// acg_core
// Decision logic: checks one command or tick against the actuator state and
// configuration, and forms the next state and up to two results.
// ----------------------------------------------------------------------------
module acg_core (
  input  acg_pkg::cfg_t cfg,
  input  acg_pkg::ast_t ast,
  input  acg_pkg::cmd_t cmd,
  output acg_pkg::ast_t ast_nxt,
  output acg_pkg::res_t res0,
  output acg_pkg::res_t res1,
  output logic          two
);
  import acg_pkg::*;

  ast_t        nx;
  logic [2:0]  act;
  logic [2:0]  err;
  logic [1:0]  kind;
  logic [31:0] val;
  logic [15:0] seq;
  logic        drv_err;
  logic [31:0] elapsed;
  logic        vel;
  logic [32:0] rel_sum;
  logic        ovf;
  logic [31:0] tgt;
  logic [31:0] mag;
  logic        soft_bad;
  logic        range_bad;
  logic        busy;

  assign elapsed  = cmd.now - ast.lht;
  assign vel      = (cmd.rtype == R_RUN_VEL);
  assign rel_sum  = {cmd.cur[31], cmd.cur} + {cmd.pos[31], cmd.pos};
  assign ovf      = (cmd.rtype == R_MOVE_REL) && (rel_sum[32] != rel_sum[31]);
  assign tgt      = (cmd.rtype == R_MOVE_REL) ? rel_sum[31:0] : cmd.pos;
  assign mag      = (vel && cmd.speed[31]) ? (~cmd.speed[31:0] + 32'd1) : cmd.speed[31:0];
  assign soft_bad = cfg.soft_on && (($signed(tgt) < $signed(cfg.soft_min)) ||
                                    ($signed(tgt) > $signed(cfg.soft_max)));
  assign range_bad = ovf || (mag == 32'd0) || (cmd.accel == 32'd0) ||
                     (mag > cfg.max_vel) || (cmd.accel > cfg.max_acc);
  assign busy = (ast.st == ST_STOPPING) ||
                (!vel && ast.st == ST_VELOCITY) ||
                (vel && ast.st == ST_MOVING);

  always_comb begin
    nx      = ast;
    act     = A_NONE;
    err     = E_OK;
    kind    = K_ACK;
    val     = '0;
    seq     = cmd.seq;
    drv_err = 1'b0;
    two     = 1'b0;
    if (cmd.rtype == R_TICK) begin
      kind = K_TICK;
      seq  = '0;
      if ((nx.st == ST_MOVING || nx.st == ST_STOPPING) && !cmd.active) begin
        nx.st   = nx.drv ? ST_IDLE : ST_DISABLED;
        nx.mode = nx.drv ? MODE_POSITION : MODE_DISABLED;
      end
      if (nx.st == ST_VELOCITY && cfg.host_tmo != 32'd0 && elapsed > cfg.host_tmo) begin
        nx.flt = nx.flt | F_TIMEOUT;
        if (cfg.tmo_dis) begin
          act     = A_ESTOP;
          nx.drv  = 1'b0;
          nx.mode = MODE_DISABLED;
          nx.st   = ST_FAULTED;
        end else begin
          act     = A_RAMP;
          val     = cfg.stop_decel;
          nx.st   = ST_STOPPING;
          nx.mode = MODE_POSITION;
        end
      end
    end else begin
      nx.lht = cmd.now;
      case (cmd.rtype) inside
        R_SET_MODE: begin
          if (!cmd.len_ok) begin
            err = E_PAYLOAD;
          end else if (ast.st == ST_FAULTED && cmd.mode != MODE_DISABLED) begin
            err = E_FAULTED;
          end else if (ast.st == ST_MOVING || ast.st == ST_VELOCITY ||
                       ast.st == ST_STOPPING) begin
            err = E_BUSY;
          end else begin
            nx.mode = cmd.mode;
            if (cmd.mode == MODE_DISABLED) begin
              nx.drv = 1'b0;
              nx.st  = ST_DISABLED;
              act    = A_DISABLE;
            end else begin
              act = A_ENABLE;
              if (!cmd.drv_ok) begin
                drv_err = 1'b1;
              end else begin
                nx.drv = 1'b1;
                nx.st  = (cmd.mode == MODE_COMM) ? ST_COMM : ST_IDLE;
              end
            end
          end
        end
        R_ESTOP: begin
          if (!cmd.len_ok) begin
            err = E_PAYLOAD;
          end else begin
            act     = A_ESTOP;
            nx.drv  = 1'b0;
            nx.mode = MODE_DISABLED;
            nx.st   = ST_FAULTED;
          end
        end
        R_RAMP_STOP: begin
          if (!cmd.len_ok) begin
            err = E_PAYLOAD;
          end else begin
            act = A_RAMP;
            if (!cmd.drv_ok) begin
              drv_err = 1'b1;
            end else begin
              nx.st   = ST_STOPPING;
              nx.mode = MODE_POSITION;
            end
          end
        end
        R_CLEAR: begin
          if (!cmd.len_ok) begin
            err = E_PAYLOAD;
          end else begin
            nx.flt = '0;
            if (!ast.drv) begin
              nx.st   = ST_DISABLED;
              nx.mode = MODE_DISABLED;
            end else begin
              nx.st = ST_IDLE;
            end
          end
        end
        R_MOVE_ABS, R_MOVE_REL, R_RUN_VEL: begin
          if (!cmd.len_ok) begin
            err = E_PAYLOAD;
          end else if (ast.st == ST_FAULTED) begin
            err = E_FAULTED;
          end else if (!ast.drv) begin
            err = E_STATE;
          end else if (busy) begin
            err = E_BUSY;
          end else if (range_bad) begin
            err = E_RANGE;
          end else if (!vel && soft_bad) begin
            nx.flt = nx.flt | F_SOFT;
            err    = E_RANGE;
          end else begin
            act = (cmd.rtype == R_MOVE_ABS) ? A_MOVE_ABS :
                  (cmd.rtype == R_MOVE_REL) ? A_MOVE_REL : A_RUN_VEL;
            if (!cmd.drv_ok) begin
              drv_err = 1'b1;
            end else begin
              nx.st   = vel ? ST_VELOCITY : ST_MOVING;
              nx.mode = vel ? MODE_VELOCITY : MODE_POSITION;
            end
          end
        end
        R_HEARTBEAT: begin
        end
        R_PING: begin
          if (!cmd.len_ok) begin
            err = E_PAYLOAD;
          end else begin
            two = 1'b1;
          end
        end
        default: begin
          nx.flt = nx.flt | F_UNSUP;
          nx.st  = ST_FAULTED;
          err    = E_UNSUP;
        end
      endcase
      if (drv_err) begin
        nx.flt = nx.flt | F_DRIVER;
        nx.st  = ST_FAULTED;
        err    = E_STATE;
      end
      if (err != E_OK) begin
        kind = K_ERR;
      end
    end

    ast_nxt     = nx;
    res0.kind   = kind;
    res0.err    = err;
    res0.seq    = seq;
    res0.st     = nx.st;
    res0.mode   = nx.mode;
    res0.drv    = nx.drv;
    res0.flt    = nx.flt;
    res0.action = act;
    res0.value  = val;
    res0.last   = !two;
    res1        = res0;
    res1.kind   = K_PONG;
    res1.last   = 1'b1;
  end

endmodule

FILE: rtl/acg_resq.sv
// ----------------------------------------------------------------------------
// acg_resq
// Result queue: takes one or two results per cycle and hands them out one
// transfer at a time on the master side of the stream.
// ----------------------------------------------------------------------------
module acg_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          push_two,
  input  acg_pkg::res_t res0,
  input  acg_pkg::res_t res1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output acg_pkg::res_t out_res
);
  import acg_pkg::*;

  res_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r;
  logic [Q_AW-1:0] wr_nxt;
  logic [Q_AW-1:0] rd_r;
  logic [Q_AW-1:0] rd_nxt;
  logic [Q_CW-1:0] cnt_r;
  logic [Q_CW-1:0] cnt_nxt;
  logic [Q_AW-1:0] wr_p1;
  logic            pop;
  logic            push2;

  assign room      = (cnt_r <= Q_CW'(Q_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign push2     = push && push_two;
  assign wr_p1     = wr_r + Q_AW'(1);

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt  = push2 ? (wr_r + Q_AW'(2)) : wr_p1;
      cnt_nxt = cnt_nxt + (push2 ? Q_CW'(2) : Q_CW'(1));
    end
    if (pop) begin
      rd_nxt  = rd_r + Q_AW'(1);
      cnt_nxt = cnt_nxt - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= res0;
    end
    if (push2) begin
      mem_r[wr_p1] <= res1;
    end
  end

endmodule

FILE: rtl/actuator_command_gatekeeper.sv
// ----------------------------------------------------------------------------
// actuator_command_gatekeeper
// Safety gate for a stepper actuator: checks host commands and ticks, keeps
// the actuator state and fault mask, and reports answers and drive actions.
// ----------------------------------------------------------------------------
// An input is registered in the command stage; its results are then written to
// the result queue. Throughput: one input per cycle while the queue has room;
// a ping yields two results and holds the output for two transfers, since the
// result queue has a single read port. Reset (synchronous, rst_n low) clears
// the actuator state, the queue and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module actuator_command_gatekeeper (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [acg_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [acg_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // seq_tag, length_ok, now_time, mode_arg, position_arg, speed_arg,
  // accel_arg, current_pos, driver_ok, backend moving flag, zero fill
  input  logic [acg_pkg::IN_DW-1:0]  in_tdata,
  // req_type
  input  logic [acg_pkg::IN_UW-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // error_code, seq_echo, state_now, mode_now, driver_on, fault_mask,
  // drive_action, drive_value, zero fill
  output logic [acg_pkg::OUT_DW-1:0] out_tdata,
  // resp_kind
  output logic [acg_pkg::OUT_UW-1:0] out_tuser,
  output logic                       out_tlast
);
  import acg_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  ast_t ast_r;
  ast_t ast_nxt;
  cmd_t cmd_r;
  cmd_t cmd_in;
  logic stg_vld_r;
  logic stg_vld_nxt;
  logic room;
  logic adv;
  logic in_acc;
  res_t res0;
  res_t res1;
  logic two;
  res_t q_res;

  assign cmd_in.rtype  = in_tuser;
  assign cmd_in.seq    = in_tdata[15:0];
  assign cmd_in.len_ok = in_tdata[16];
  assign cmd_in.now    = in_tdata[48:17];
  assign cmd_in.mode   = in_tdata[56:49];
  assign cmd_in.pos    = in_tdata[88:57];
  assign cmd_in.speed  = in_tdata[121:89];
  assign cmd_in.accel  = in_tdata[153:122];
  assign cmd_in.cur    = in_tdata[185:154];
  assign cmd_in.drv_ok = in_tdata[186];
  assign cmd_in.active = in_tdata[187];

  assign adv         = stg_vld_r && room;
  assign in_tready   = !stg_vld_r || room;
  assign in_acc      = in_tvalid && in_tready;
  assign stg_vld_nxt = in_acc ? 1'b1 : (adv ? 1'b0 : stg_vld_r);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SOFT_ON:    cfg_nxt.soft_on    = cfg_wdata[0];
        CFG_SOFT_MIN:   cfg_nxt.soft_min   = cfg_wdata;
        CFG_SOFT_MAX:   cfg_nxt.soft_max   = cfg_wdata;
        CFG_MAX_VEL:    cfg_nxt.max_vel    = cfg_wdata;
        CFG_MAX_ACC:    cfg_nxt.max_acc    = cfg_wdata;
        CFG_HOST_TMO:   cfg_nxt.host_tmo   = cfg_wdata;
        CFG_TMO_DIS:    cfg_nxt.tmo_dis    = cfg_wdata[0];
        CFG_STOP_DECEL: cfg_nxt.stop_decel = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.soft_on    <= 1'b0;
      cfg_r.soft_min   <= 32'sh8000_0000;
      cfg_r.soft_max   <= 32'sh7FFF_FFFF;
      cfg_r.max_vel    <= '1;
      cfg_r.max_acc    <= '1;
      cfg_r.host_tmo   <= '0;
      cfg_r.tmo_dis    <= 1'b0;
      cfg_r.stop_decel <= '0;
      ast_r.st         <= ST_DISABLED;
      ast_r.mode       <= MODE_DISABLED;
      ast_r.drv        <= 1'b0;
      ast_r.flt        <= '0;
      ast_r.lht        <= '0;
      stg_vld_r        <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      stg_vld_r <= stg_vld_nxt;
      if (adv) begin
        ast_r <= ast_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= cmd_in;
    end
  end

  acg_core u_core (
    .cfg     (cfg_r),
    .ast     (ast_r),
    .cmd     (cmd_r),
    .ast_nxt (ast_nxt),
    .res0    (res0),
    .res1    (res1),
    .two     (two)
  );

  acg_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .push_two  (two),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (q_res)
  );

  assign out_tuser = q_res.kind;
  assign out_tlast = q_res.last;
  assign out_tdata = {2'b00, q_res.value, q_res.action, q_res.flt, q_res.drv,
                      q_res.mode, q_res.st, q_res.seq, q_res.err};

endmodule

FILE: test/actuator_command_gatekeeper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actuator_command_gatekeeper_tb
// Self-checking bench for the actuator command gatekeeper. Directed commands
// walk the state machine, the soft limits and the host timeout, then random
// traffic runs under several register settings, with random stalls on both
// streams in all but one setting. Every result transfer is checked field by
// field against a behavioral model of the gate kept inside the bench.
// ----------------------------------------------------------------------------
module actuator_command_gatekeeper_tb;
  import acg_pkg::*;

  localparam int          LIM_FLOOR    = 32'sh8000_0000;
  localparam int          LIM_CEIL     = 32'sh7FFF_FFFF;
  localparam logic [3:0]  REQ_UNSUP_LO = 4'd10;
  localparam logic [3:0]  REQ_UNSUP_HI = 4'd15;
  localparam int          IDLE_PCT     = 36;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          STALL_LIMIT  = 2000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;
  logic [IN_UW-1:0]    in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic [OUT_UW-1:0]   out_tuser;
  logic                out_tlast;

  actuator_command_gatekeeper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // Gate model: registers and actuator state.
  logic        lim_on;
  longint      lim_min, lim_max;
  logic [31:0] vel_cap, acc_cap, host_tmo, tmo_decel;
  logic        tmo_hard;
  st_t         act_st;
  logic [7:0]  act_mode;
  logic        drv_on;
  logic [3:0]  flt_mask;
  logic [31:0] host_seen;

  res_t        expected_responses[$];
  res_t        want;
  int          error_count = 0;

  logic        src_steady, sink_steady;
  int          hold_req, hold_ack, hold_left;
  logic [31:0] clock_ms;
  int          tick_run;

  task automatic reset_model();
    lim_on    = 1'b0;
    lim_min   = -64'sd2147483648;
    lim_max   = 64'sd2147483647;
    vel_cap   = '1;
    acc_cap   = '1;
    host_tmo  = '0;
    tmo_hard  = 1'b0;
    tmo_decel = '0;
    act_st    = ST_DISABLED;
    act_mode  = MODE_DISABLED;
    drv_on    = 1'b0;
    flt_mask  = '0;
    host_seen = '0;
  endtask

  task automatic push_response(logic [1:0] kind, logic [2:0] err, logic [15:0] seq,
                               logic [2:0] action, logic [31:0] value, logic last);
    res_t r;
    r.kind   = kind;
    r.err    = err;
    r.seq    = seq;
    r.st     = act_st;
    r.mode   = act_mode;
    r.drv    = drv_on;
    r.flt    = flt_mask;
    r.action = action;
    r.value  = value;
    r.last   = last;
    expected_responses.push_back(r);
  endtask

  task automatic gate_predict(input cmd_t c);
    logic [3:0]  rt;
    logic [2:0]  act, rerr;
    logic [31:0] elapsed, decel;
    logic        drv_fault, is_vel;
    longint      tgt, mag, spd;
    int          p, q, sv;
    rt        = c.rtype;
    act       = A_NONE;
    rerr      = E_OK;
    drv_fault = 1'b0;
    decel     = '0;
    if (rt == R_TICK) begin
      if ((act_st == ST_MOVING || act_st == ST_STOPPING) && !c.active) begin
        act_st   = drv_on ? ST_IDLE : ST_DISABLED;
        act_mode = drv_on ? MODE_POSITION : MODE_DISABLED;
      end
      elapsed = c.now - host_seen;
      if (act_st == ST_VELOCITY && host_tmo != 0 && elapsed > host_tmo) begin
        flt_mask |= F_TIMEOUT;
        if (tmo_hard) begin
          act      = A_ESTOP;
          drv_on   = 1'b0;
          act_mode = MODE_DISABLED;
          act_st   = ST_FAULTED;
        end else begin
          act      = A_RAMP;
          decel    = tmo_decel;
          act_st   = ST_STOPPING;
          act_mode = MODE_POSITION;
        end
      end
      push_response(K_TICK, E_OK, '0, act, decel, 1'b1);
      return;
    end
    host_seen = c.now;
    if (rt > R_PING) begin
      flt_mask |= F_UNSUP;
      act_st   = ST_FAULTED;
      rerr     = E_UNSUP;
    end else if (rt == R_HEARTBEAT) begin
      rerr = E_OK;
    end else if (!c.len_ok) begin
      rerr = E_PAYLOAD;
    end else begin
      case (rt)
        R_SET_MODE: begin
          if (act_st == ST_FAULTED && c.mode != MODE_DISABLED) begin
            rerr = E_FAULTED;
          end else if (act_st == ST_MOVING || act_st == ST_VELOCITY ||
                       act_st == ST_STOPPING) begin
            rerr = E_BUSY;
          end else begin
            act_mode = c.mode;
            if (c.mode == MODE_DISABLED) begin
              drv_on = 1'b0;
              act_st = ST_DISABLED;
              act    = A_DISABLE;
            end else begin
              act = A_ENABLE;
              if (!c.drv_ok) begin
                drv_fault = 1'b1;
              end else begin
                drv_on = 1'b1;
                act_st = (c.mode == MODE_COMM) ? ST_COMM : ST_IDLE;
              end
            end
          end
        end
        R_ESTOP: begin
          act      = A_ESTOP;
          drv_on   = 1'b0;
          act_mode = MODE_DISABLED;
          act_st   = ST_FAULTED;
        end
        R_RAMP_STOP: begin
          act = A_RAMP;
          if (!c.drv_ok) begin
            drv_fault = 1'b1;
          end else begin
            act_st   = ST_STOPPING;
            act_mode = MODE_POSITION;
          end
        end
        R_CLEAR: begin
          flt_mask = '0;
          if (!drv_on) begin
            act_st   = ST_DISABLED;
            act_mode = MODE_DISABLED;
          end else begin
            act_st = ST_IDLE;
          end
        end
        R_PING: begin
          rerr = E_OK;
        end
        default: begin
          is_vel = (rt == R_RUN_VEL);
          if (act_st == ST_FAULTED) begin
            rerr = E_FAULTED;
          end else if (!drv_on) begin
            rerr = E_STATE;
          end else if ((!is_vel && act_st == ST_VELOCITY) || (is_vel && act_st == ST_MOVING) ||
                       act_st == ST_STOPPING) begin
            rerr = E_BUSY;
          end else begin
            sv  = c.speed[31:0];
            spd = longint'(sv);
            if (is_vel) mag = (spd < 0) ? -spd : spd;
            else mag = longint'(c.speed[31:0]);
            p   = c.pos;
            q   = c.cur;
            tgt = 0;
            if (rt == R_MOVE_ABS) tgt = longint'(p);
            if (rt == R_MOVE_REL) tgt = longint'(p) + longint'(q);
            if (tgt != longint'(int'(tgt)) || mag == 0 || c.accel == 0 ||
                mag > vel_cap || c.accel > acc_cap) begin
              rerr = E_RANGE;
            end else if (!is_vel && lim_on && (tgt < lim_min || tgt > lim_max)) begin
              flt_mask |= F_SOFT;
              rerr     = E_RANGE;
            end else begin
              act = is_vel ? A_RUN_VEL : ((rt == R_MOVE_ABS) ? A_MOVE_ABS : A_MOVE_REL);
              if (!c.drv_ok) begin
                drv_fault = 1'b1;
              end else begin
                act_st   = is_vel ? ST_VELOCITY : ST_MOVING;
                act_mode = is_vel ? MODE_VELOCITY : MODE_POSITION;
              end
            end
          end
        end
      endcase
    end
    if (drv_fault) begin
      flt_mask |= F_DRIVER;
      act_st   = ST_FAULTED;
      rerr     = E_STATE;
    end
    if (rerr != E_OK) begin
      push_response(K_ERR, rerr, c.seq, act, '0, 1'b1);
    end else if (rt == R_PING) begin
      push_response(K_ACK, E_OK, c.seq, A_NONE, '0, 1'b0);
      push_response(K_PONG, E_OK, c.seq, A_NONE, '0, 1'b1);
    end else begin
      push_response(K_ACK, E_OK, c.seq, act, '0, 1'b1);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_responses.size() == 0) begin
        $display("%0t: result transfer with nothing expected, tuser %0h tdata %0h",
                 $time, out_tuser, out_tdata);
        error_count++;
      end else begin
        want = expected_responses.pop_front();
        check_field("resp_kind", want.kind, out_tuser);
        check_field("error_code", want.err, out_tdata[2:0]);
        check_field("seq_echo", want.seq, out_tdata[18:3]);
        check_field("state_now", want.st, out_tdata[21:19]);
        check_field("mode_now", want.mode, out_tdata[29:22]);
        check_field("driver_on", want.drv, out_tdata[30]);
        check_field("fault_mask", want.flt, out_tdata[34:31]);
        check_field("drive_action", want.action, out_tdata[37:35]);
        check_field("drive_value", want.value, out_tdata[69:38]);
        check_field("last_of_run", want.last, out_tlast);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, expected_responses.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    hold_ack   = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (sink_steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_item(input cmd_t c);
    if (!src_steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.rtype;
    in_tdata  <= {4'b0, c.active, c.drv_ok, c.cur, c.accel, c.speed, c.pos, c.mode,
                  c.now, c.len_ok, c.seq};
    do @(posedge clk); while (!in_tready);
    gate_predict(c);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
    int sval;
    sval = val;
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_SOFT_ON:    lim_on    = val[0];
      CFG_SOFT_MIN:   lim_min   = longint'(sval);
      CFG_SOFT_MAX:   lim_max   = longint'(sval);
      CFG_MAX_VEL:    vel_cap   = val;
      CFG_MAX_ACC:    acc_cap   = val;
      CFG_HOST_TMO:   host_tmo  = val;
      CFG_TMO_DIS:    tmo_hard  = val[0];
      CFG_STOP_DECEL: tmo_decel = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(logic on, int smin, int smax, logic [31:0] vel,
                              logic [31:0] acc, logic [31:0] tmo, logic hard,
                              logic [31:0] decel);
    wait_drained();
    write_reg(CFG_SOFT_ON, {31'b0, on});
    write_reg(CFG_SOFT_MIN, smin);
    write_reg(CFG_SOFT_MAX, smax);
    write_reg(CFG_MAX_VEL, vel);
    write_reg(CFG_MAX_ACC, acc);
    write_reg(CFG_HOST_TMO, tmo);
    write_reg(CFG_TMO_DIS, {31'b0, hard});
    write_reg(CFG_STOP_DECEL, decel);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic cmd_t base_cmd(logic [3:0] rt);
    cmd_t c;
    c.rtype  = rt;
    c.seq    = 16'($urandom);
    c.len_ok = 1'b1;
    c.now    = clock_ms;
    c.mode   = MODE_POSITION;
    c.pos    = 0;
    c.speed  = 33'd100;
    c.accel  = 32'd100;
    c.cur    = 0;
    c.drv_ok = 1'b1;
    c.active = 1'b0;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t        c;
    logic [3:0]  rt;
    logic [31:0] v;
    int          pick, s;
    pick = $urandom_range(0, 99);
    if (tick_run > 0) begin
      tick_run--;
      rt = R_TICK;
    end else if (pick < 6) begin
      tick_run = $urandom_range(2, 7);
      rt = R_TICK;
    end else if (pick < 22) rt = R_TICK;
    else if (pick < 32) rt = R_SET_MODE;
    else if (pick < 35) rt = R_ESTOP;
    else if (pick < 40) rt = R_RAMP_STOP;
    else if (pick < 48) rt = R_CLEAR;
    else if (pick < 60) rt = R_MOVE_ABS;
    else if (pick < 70) rt = R_MOVE_REL;
    else if (pick < 80) rt = R_RUN_VEL;
    else if (pick < 85) rt = R_HEARTBEAT;
    else if (pick < 93) rt = R_PING;
    else if (pick < 96) rt = 4'($urandom_range(REQ_UNSUP_LO, REQ_UNSUP_HI));
    else rt = 4'($urandom);
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 20);
    c = base_cmd(rt);
    c.len_ok = ($urandom_range(0, 99) >= 6);
    if ($urandom_range(0, 99) < 15) c.mode = 8'($urandom);
    else c.mode = 8'($urandom_range(MODE_DISABLED, MODE_COMM));
    if ($urandom_range(0, 99) < 15) c.pos = $urandom;
    else c.pos = int'($urandom_range(0, 4000)) - 2000;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      c.speed = '0;
    end else if (pick < 20) begin
      v = $urandom;
      c.speed = (v[31] && $urandom_range(0, 1)) ? {1'b1, v} : {1'b0, v};
    end else begin
      s = $urandom_range(1, 1200);
      if (rt == R_RUN_VEL && $urandom_range(0, 1)) s = -s;
      c.speed = {s[31], s};
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) c.accel = '0;
    else if (pick < 15) c.accel = $urandom;
    else c.accel = $urandom_range(1, 1200);
    if ($urandom_range(0, 99) < 15) c.cur = $urandom;
    else c.cur = int'($urandom_range(0, 6000)) - 3000;
    c.drv_ok = ($urandom_range(0, 99) >= 5);
    c.active = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic test_command_set();
    cmd_t c;
    c = base_cmd(R_PING);      c.len_ok = 1'b0; c.seq = '0; send_item(c);
    c = base_cmd(R_MOVE_ABS);  send_item(c);
    c = base_cmd(R_SET_MODE);  c.mode = MODE_COMM; c.seq = '1; send_item(c);
    c = base_cmd(R_SET_MODE);  c.mode = 8'hFF; send_item(c);
    c = base_cmd(R_MOVE_REL);  c.cur = LIM_CEIL; c.pos = 1; send_item(c);
    c = base_cmd(R_RUN_VEL);   c.speed = '0; send_item(c);
    c = base_cmd(R_MOVE_ABS);
    c.pos = LIM_FLOOR; c.cur = LIM_FLOOR; c.speed = 33'h0_FFFF_FFFF; c.accel = '1;
    send_item(c);
    c = base_cmd(R_RUN_VEL);   send_item(c);
    c = base_cmd(R_TICK);      c.active = 1'b1; send_item(c);
    c = base_cmd(R_TICK);      send_item(c);
    c = base_cmd(R_RUN_VEL);   c.speed = 33'h1_8000_0000; c.accel = 32'd1; send_item(c);
    c = base_cmd(R_MOVE_ABS);  c.pos = LIM_CEIL; send_item(c);
    c = base_cmd(R_HEARTBEAT); c.len_ok = 1'b0; c.now = '1; send_item(c);
    c = base_cmd(R_PING);      send_item(c);
    c = base_cmd(R_RAMP_STOP); c.drv_ok = 1'b0; send_item(c);
    c = base_cmd(R_SET_MODE);  c.mode = MODE_VELOCITY; send_item(c);
    c = base_cmd(R_SET_MODE);  c.mode = MODE_DISABLED; send_item(c);
    c = base_cmd(R_CLEAR);     send_item(c);
    c = base_cmd(R_SET_MODE);  c.drv_ok = 1'b0; send_item(c);
    c = base_cmd(REQ_UNSUP_HI); send_item(c);
    c = base_cmd(R_ESTOP);     c.active = 1'b1; send_item(c);
    c = base_cmd(R_CLEAR);     send_item(c);
  endtask

  task automatic test_soft_limits();
    cmd_t c;
    program_regs(1'b1, -100, 100, 32'd1000, 32'd1000, 32'd0, 1'b0, 32'd0);
    c = base_cmd(R_SET_MODE); send_item(c);
    c = base_cmd(R_MOVE_ABS); c.pos = 101; send_item(c);
    c = base_cmd(R_MOVE_REL); c.cur = -100; c.pos = 0; send_item(c);
    c = base_cmd(R_TICK);     send_item(c);
    c = base_cmd(R_MOVE_ABS); c.speed = 33'd1001; send_item(c);
    c = base_cmd(R_MOVE_ABS); c.accel = 32'd1001; send_item(c);
    program_regs(1'b1, 5, -5, '1, '1, 32'd0, 1'b0, 32'd0);
    c = base_cmd(R_MOVE_ABS); send_item(c);
  endtask

  task automatic test_host_timeout();
    cmd_t c;
    program_regs(1'b0, LIM_FLOOR, LIM_CEIL, '1, '1, 32'd20, 1'b0, '1);
    c = base_cmd(R_RUN_VEL); c.now = 32'd1000; send_item(c);
    c = base_cmd(R_TICK);    c.now = 32'd1020; send_item(c);
    c = base_cmd(R_TICK);    c.now = 32'd1021; c.active = 1'b1; send_item(c);
    c = base_cmd(R_TICK);    c.now = 32'd1022; send_item(c);
    program_regs(1'b0, LIM_FLOOR, LIM_CEIL, '1, '1, 32'd20, 1'b1, '1);
    c = base_cmd(R_RUN_VEL); c.now = 32'hFFFF_FFF0; send_item(c);
    c = base_cmd(R_TICK);    c.now = 32'd5; send_item(c);
    clock_ms = 32'd6;
    c = base_cmd(R_CLEAR);   send_item(c);
  endtask

  // The result stream is held off while items keep coming, so the result
  // queue fills and the input stream has to stall.
  task automatic test_backpressure();
    program_regs(1'b1, -1500, 1500, 32'd1000, 32'd1000, 32'd25, 1'b0, 32'd77);
    hold_req++;
    src_steady = 1'b1;
    repeat (30) send_item(rand_cmd());
    src_steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int count;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_regs(1'b0, LIM_FLOOR, LIM_CEIL, '1, '1, 32'd0, 1'b0, 32'd0);
        1: program_regs(1'b1, -1500, 1500, 32'd800, 32'd400, 32'd25, 1'b0, $urandom);
        2: program_regs(1'b1, 100, -100, 32'd0, '1, 32'd1, 1'b1, '1);
        3: program_regs(1'b1, LIM_FLOOR, LIM_CEIL, $urandom, $urandom, '1, 1'b1, $urandom);
        4: program_regs(1'b1, 0, 0, 32'd1000, 32'd1000, 32'd30, 1'($urandom), $urandom);
        default: program_regs(1'($urandom), -int'($urandom_range(0, 3000)),
                              int'($urandom_range(0, 3000)), $urandom_range(0, 2000),
                              $urandom_range(0, 2000), $urandom_range(0, 60),
                              1'($urandom), $urandom);
      endcase
      count = (phase == 2) ? 150 : 260;
      src_steady  = (phase == 2);
      sink_steady = (phase == 2);
      repeat (count) send_item(rand_cmd());
      src_steady  = 1'b0;
      sink_steady = 1'b0;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    hold_req    = 0;
    clock_ms    = 32'd100;
    tick_run    = 0;
    reset_model();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_command_set();
    test_soft_limits();
    test_host_timeout();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (8) @(negedge clk);
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
